>>> sv/pmr_pkg.sv
// Shared types and constants for the polygon mask rasterizer.
// Used by the top level, the grid divider and the port checker.
`default_nettype none

package pmr_pkg;

  localparam int COORD_W = 40;
  localparam int SPAN_W  = 42;
  localparam int RES_W   = 16;
  localparam int PAD_W   = 24;
  localparam int DIM_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OFFGRID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD = 1'b1;

  localparam logic [RES_W-1:0] RES_RESET = 16'd128;
  localparam logic [PAD_W-1:0] PAD_RESET = 24'd12800;
  localparam logic [DIM_W-1:0] DIM_CAP   = 16'hFFFF;
  localparam logic [7:0] PIX_INSIDE = 8'd255;

  // Request to the grid divider: one pulse starts a ceiling division.
  typedef struct packed {
    logic              start;
    logic              empty;
    logic [SPAN_W-1:0] span;
  } pmr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] dim;
  } pmr_div_rsp_t;

endpackage

`default_nettype wire

>>> sv/polygon_mask_rasterizer_unit.sv
// Polygon mask rasterizer top level: vertex memory, bounds, crossing test.
// Depends on pmr_pkg and pmr_grid_div.
//
// Usage. Words arrive on the input channel (in_valid / in_stall) and one
// result word per input word leaves on the output channel (out_valid /
// out_stall). A word is taken at a clock edge where valid is high and stall
// is low. cmd 0 clears the polygon, cmd 1 appends a vertex, cmd 2 classifies
// one grid cell. The user writes cell size and padding on the cfg port only
// while the block is idle; the block itself does not enforce this.
//
// Operation. The block works on one word at a time. Every word first runs the
// grid divider twice (width, then height); each division ends early when
// the polygon is empty or its span saturates. A classify word then walks
// the vertex memory: it primes the first edge, passes once through each
// edge that does not straddle the cell center row, and for each edge that
// does forms the exact cross product with two 45x17 multipliers, one 16-bit
// chunk of the multiplier operands at a time, before the crossing is counted.
//
// The result sits in an output register, so the next word is taken while an
// earlier result waits on a stalled receiver; a finished word waits only if
// that register is still full. Reset empties the polygon, zeroes the bounds,
// loads the default cell size and padding and drops any pending result. The
// vertex memory is not cleared; the vertex count keeps reads within writes.
`default_nettype none

module polygon_mask_rasterizer_unit
  import pmr_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [PAD_W-1:0]            cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  cmd,
  input  wire logic signed [COORD_W-1:0]   vertex_x,
  input  wire logic signed [COORD_W-1:0]   vertex_y,
  input  wire logic [15:0]                 cell_col,
  input  wire logic [15:0]                 cell_row,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic                             inside_res,
  output logic [7:0]                       pixel_value,
  output logic [31:0]                      pixel_index,
  output logic [DIM_W-1:0]                 grid_width,
  output logic [DIM_W-1:0]                 grid_height
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_VERTICES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIVW  = 10'b0000000010,
    S_DIVH  = 10'b0000000100,
    S_CHECK = 10'b0000001000,
    S_RDJ   = 10'b0000010000,
    S_LDJ   = 10'b0000100000,
    S_EDGE  = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration.
  logic [RES_W-1:0] resolution;
  logic [PAD_W-1:0] padding;
  logic [RES_W-1:0] res_eff;

  // Polygon state.
  logic [2*COORD_W-1:0] vstore [MAX_VERTICES];
  logic [2*COORD_W-1:0] rdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [CW-1:0]        vcount;
  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;

  // Latched word and result.
  logic [1:0]       cmd_q;
  logic [15:0]      col_q, row_q;
  logic [1:0]       r_status;
  logic             r_inside;
  logic [31:0]      r_index;
  logic [DIM_W-1:0] dim_w, dim_h;

  // Crossing walk.
  logic signed [43:0] px, py;
  logic signed [COORD_W-1:0] jx, jy, cx, cy;
  logic [AW-1:0]      ei;
  logic               last;
  logic signed [44:0] op_a, op_c;
  logic signed [47:0] op_b, op_d;
  logic               d_neg;
  logic [1:0]         mk;
  logic signed [95:0] acc;

  // Divider hookup.
  pmr_div_req_t div_req;
  pmr_div_rsp_t div_rsp;
  logic         div_go;

  assign res_eff  = (resolution == '0) ? RES_W'(1) : resolution;
  assign in_stall = (state != S_IDLE);
  assign last     = (CW'(ei) == vcount - CW'(1));

  always_comb begin
    div_req.start = div_go;
    div_req.empty = (vcount == '0);
    // The difference of two 40-bit signed bounds needs 41 bits, so both are
    // sign-extended to the span width before subtracting.
    if (state == S_DIVW) begin
      div_req.span = SPAN_W'({{2{max_x[COORD_W-1]}}, max_x} - {{2{min_x[COORD_W-1]}}, min_x})
                     + SPAN_W'({padding, 1'b0});
    end else begin
      div_req.span = SPAN_W'({{2{max_y[COORD_W-1]}}, max_y} - {{2{min_y[COORD_W-1]}}, min_y})
                     + SPAN_W'({padding, 1'b0});
    end
  end

  pmr_grid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (res_eff),
    .rsp (div_rsp)
  );

  // Edge data for the vertex now on the memory read port.
  logic signed [COORD_W-1:0] xi, yi;
  logic                      straddle;
  assign xi = rdata[2*COORD_W-1:COORD_W];
  assign yi = rdata[COORD_W-1:0];
  assign straddle = (44'(yi) > py) != (44'(jy) > py);

  // Cross-product slice: both products times the same 16-bit chunk of B and D.
  logic signed [16:0] ch_b, ch_d;
  logic signed [61:0] p_ab, p_cd;
  logic signed [95:0] acc_next;

  always_comb begin
    case (mk)
      2'd0: begin
        ch_b = {op_b[47], op_b[47:32]};
        ch_d = {op_d[47], op_d[47:32]};
      end
      2'd1: begin
        ch_b = {1'b0, op_b[31:16]};
        ch_d = {1'b0, op_d[31:16]};
      end
      default: begin
        ch_b = {1'b0, op_b[15:0]};
        ch_d = {1'b0, op_d[15:0]};
      end
    endcase
    p_ab = op_a * ch_b;
    p_cd = op_c * ch_d;
    acc_next = ((mk == 2'd0) ? 96'sd0 : (acc <<< 16)) + 96'(p_ab) - 96'(p_cd);
  end

  // Cell center and image index for the latched column and row.
  logic [31:0]        colres, rowres, idx_mul;
  logic signed [43:0] px_calc, py_calc;
  logic [DIM_W-1:0]   flip_row;
  always_comb begin
    colres   = col_q * res_eff;
    rowres   = row_q * res_eff;
    px_calc  = 44'(min_x) - $signed({20'b0, padding}) + $signed({12'b0, colres})
               + $signed({29'b0, res_eff[RES_W-1:1]});
    py_calc  = 44'(min_y) - $signed({20'b0, padding}) + $signed({12'b0, rowres})
               + $signed({29'b0, res_eff[RES_W-1:1]});
    flip_row = dim_h - DIM_W'(1) - row_q;
    idx_mul  = flip_row * dim_w;
  end

  // Read address for the walk.
  always_comb begin
    re    = 1'b0;
    raddr = ei + AW'(1);
    unique case (state)
      S_RDJ: begin
        re    = 1'b1;
        raddr = AW'(vcount - CW'(1));
      end
      S_LDJ: begin
        re    = 1'b1;
        raddr = '0;
      end
      S_EDGE:  re = !straddle && !last;
      S_NEXT:  re = !last;
      default: re = 1'b0;
    endcase
  end

  // Vertex memory: written on append, read during the walk.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && cmd == CMD_APPEND && vcount != COUNT_FULL) begin
      vstore[AW'(vcount)] <= {vertex_x, vertex_y};
    end
    if (re) begin
      rdata <= vstore[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resolution <= RES_RESET;
      padding    <= PAD_RESET;
      vcount     <= '0;
      min_x      <= '0;
      max_x      <= '0;
      min_y      <= '0;
      max_y      <= '0;
      div_go     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The divider starts once for the width and once for the height.
      div_go <= (state == S_IDLE && in_valid) || (state == S_DIVW && div_rsp.done);
      // A taken result empties the output register unless a new one lands.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_RES: resolution <= cfg_data[RES_W-1:0];
          REG_PAD: padding    <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd;
            col_q    <= cell_col;
            row_q    <= cell_row;
            r_status <= (cmd == CMD_APPEND && vcount == COUNT_FULL) ? ST_FULL : ST_OK;
            r_inside <= 1'b0;
            r_index  <= '0;
            if (cmd == CMD_CLEAR) begin
              vcount <= '0;
              min_x  <= '0;
              max_x  <= '0;
              min_y  <= '0;
              max_y  <= '0;
            end else if (cmd == CMD_APPEND) begin
              if (vcount != COUNT_FULL) begin
                if (vcount == '0 || vertex_x < min_x) min_x <= vertex_x;
                if (vcount == '0 || vertex_x > max_x) max_x <= vertex_x;
                if (vcount == '0 || vertex_y < min_y) min_y <= vertex_y;
                if (vcount == '0 || vertex_y > max_y) max_y <= vertex_y;
                vcount <= vcount + CW'(1);
              end
            end
            state  <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            dim_w  <= div_rsp.dim;
            state  <= S_DIVH;
          end
        end
        S_DIVH: begin
          if (div_rsp.done) begin
            dim_h <= div_rsp.dim;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cmd_q != CMD_CLASSIFY) begin
            state <= S_DONE;
          end else if (col_q >= dim_w || row_q >= dim_h) begin
            r_status <= ST_OFFGRID;
            state    <= S_DONE;
          end else begin
            px      <= px_calc;
            py      <= py_calc;
            r_index <= idx_mul + {16'b0, col_q};
            ei      <= '0;
            state   <= S_RDJ;
          end
        end
        S_RDJ: state <= S_LDJ;
        S_LDJ: begin
          jx    <= xi;
          jy    <= yi;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (straddle) begin
            cx    <= xi;
            cy    <= yi;
            op_a  <= 45'(px) - 45'(xi);
            op_c  <= 45'(jx) - 45'(xi);
            op_b  <= 48'(jy) - 48'(yi);
            op_d  <= 48'(py) - 48'(yi);
            d_neg <= (jy < yi);
            mk    <= 2'd0;
            state <= S_MUL;
          end else begin
            jx <= xi;
            jy <= yi;
            if (last) begin
              state <= S_DONE;
            end else begin
              ei <= ei + AW'(1);
            end
          end
        end
        S_MUL: begin
          acc <= acc_next;
          mk  <= mk + 2'd1;
          if (mk == 2'd2) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          // Toggle when the sign of the cross difference opposes the edge's dy.
          if ((!d_neg && acc[95]) || (d_neg && !acc[95] && acc != '0)) begin
            r_inside <= !r_inside;
          end
          jx <= cx;
          jy <= cy;
          if (last) begin
            state <= S_DONE;
          end else begin
            ei    <= ei + AW'(1);
            state <= S_EDGE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= r_status;
            inside_res  <= r_inside;
            pixel_value <= r_inside ? PIX_INSIDE : 8'd0;
            pixel_index <= r_index;
            grid_width  <= dim_w;
            grid_height <= dim_h;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/pmr_grid_div.sv
// Ceiling division of a padded span by the cell size, saturated to 16 bits.
// Restoring divider, one quotient bit per cycle; depends on pmr_pkg.
`default_nettype none

module pmr_grid_div
  import pmr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pmr_div_req_t req,
  input  wire logic [RES_W-1:0] res,
  output pmr_div_rsp_t      rsp
);

  logic             busy;
  logic [4:0]       cnt;
  logic [RES_W-1:0] rem;
  logic [15:0]      sh;
  logic [DIM_W-1:0] q;

  logic [RES_W:0]   rem2;
  logic             ge;
  logic [RES_W-1:0] rem_next;
  logic [DIM_W-1:0] q_next;
  logic [DIM_W:0]   n_ceil;
  logic             sat;

  always_comb begin
    rem2     = {rem, sh[15]};
    ge       = rem2 >= {1'b0, res};
    rem_next = ge ? RES_W'(rem2 - {1'b0, res}) : rem2[RES_W-1:0];
    q_next   = {q[DIM_W-2:0], ge};
    n_ceil   = {1'b0, q_next} + (DIM_W+1)'(rem_next != '0);
    // A quotient of 2^16 or more shows as the upper span bits reaching res.
    sat      = req.span >= {10'b0, res, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (req.start && (req.empty || sat)) || (!req.start && busy && cnt == 5'd1);
      if (req.start) begin
        if (req.empty) begin
          rsp.dim  <= '0;
        end else if (sat) begin
          rsp.dim  <= DIM_CAP;
        end else begin
          rem  <= req.span[31:16];
          sh   <= req.span[15:0];
          q    <= '0;
          cnt  <= 5'd16;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        q   <= q_next;
        sh  <= {sh[14:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy     <= 1'b0;
          rsp.dim  <= n_ceil[DIM_W] ? DIM_CAP : n_ceil[DIM_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/pmr_checker.sv
// Port-level checks for the polygon mask rasterizer, bound to the top level.
// Depends on pmr_pkg.
`default_nettype none

module pmr_checker
  import pmr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic        inside_res,
  input wire logic [7:0]  pixel_value,
  input wire logic [31:0] pixel_index
);

  // One word at a time: a taken word holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel_index))
    else $error("stalled result changed");

  a_pixel_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_value == (inside_res ? PIX_INSIDE : 8'd0)))
    else $error("mask byte disagrees with inside flag");

  a_offgrid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !inside_res && pixel_index == '0)
    else $error("non-ok result carries cell data");

endmodule

bind polygon_mask_rasterizer_unit pmr_checker u_pmr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .inside_res  (inside_res),
  .pixel_value (pixel_value),
  .pixel_index (pixel_index)
);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for polygon_mask_rasterizer_unit.
// Depends on pmr_pkg and the RTL of the block; a scoreboard class predicts
// every result word from the accepted input words.
`timescale 1ns / 100ps

module tb;
  import pmr_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  pixel;
    logic [31:0] index;
    logic [15:0] width;
    logic [15:0] height;
  } cell_result_t;

  // Predicts the rasterizer and holds the result words still to come.
  class mask_scoreboard;
    longint       vx[TABLE_DEPTH];
    longint       vy[TABLE_DEPTH];
    int           nverts;
    longint       min_x, max_x, min_y, max_y;
    logic [15:0]  cell_size;
    logic [23:0]  margin;
    cell_result_t awaited[$];
    int           errors;
    int           inside_hits;
    int           full_hits;
    int           offgrid_hits;

    function new();
      nverts = 0;
      min_x = 0; max_x = 0; min_y = 0; max_y = 0;
      cell_size = RES_RESET;
      margin = PAD_RESET;
      errors = 0;
      inside_hits = 0; full_hits = 0; offgrid_hits = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
      if (idx == REG_RES) cell_size = value[15:0];
      else margin = value;
    endfunction

    function logic [63:0] step_size();
      return (cell_size == 0) ? 64'd1 : 64'(cell_size);
    endfunction

    // Padded extent of one axis in cells, rounded up and capped.
    function logic [15:0] axis_cells(longint lo, longint hi);
      logic [63:0] span, n, r;
      if (nverts == 0) return 16'd0;
      r = step_size();
      span = 64'(hi - lo) + 2 * 64'(margin);
      n = span / r + 64'((span % r) != 0);
      return (n > 64'(DIM_CAP)) ? DIM_CAP : n[15:0];
    endfunction

    function logic [15:0] cur_w();
      return axis_cells(min_x, max_x);
    endfunction

    function logic [15:0] cur_h();
      return axis_cells(min_y, max_y);
    endfunction

    // Even-odd crossing test with exact wide products.
    function bit crossing_test(longint px, longint py);
      bit in;
      int j;
      longint d;
      logic signed [127:0] ax, ad, bx, by, lhs, rhs;
      in = 0;
      j = nverts - 1;
      for (int i = 0; i < nverts; i++) begin
        if ((vy[i] > py) != (vy[j] > py)) begin
          d = vy[j] - vy[i];
          ax = px - vx[i];
          ad = d;
          bx = vx[j] - vx[i];
          by = py - vy[i];
          lhs = ax * ad;
          rhs = bx * by;
          if ((d > 0 && lhs < rhs) || (d < 0 && lhs > rhs)) in = !in;
        end
        j = i;
      end
      return in;
    endfunction

    function void note_word(logic [1:0] c, logic signed [39:0] x, logic signed [39:0] y,
                            logic [15:0] col, logic [15:0] row);
      cell_result_t e;
      longint sx, sy, px, py, r;
      e = '0;
      sx = x;
      sy = y;
      if (c == CMD_CLEAR) begin
        nverts = 0;
        min_x = 0; max_x = 0; min_y = 0; max_y = 0;
      end else if (c == CMD_APPEND) begin
        if (nverts >= TABLE_DEPTH) begin
          e.status = ST_FULL;
          full_hits++;
        end else begin
          if (nverts == 0) begin
            min_x = sx; max_x = sx; min_y = sy; max_y = sy;
          end else begin
            if (sx < min_x) min_x = sx;
            if (sx > max_x) max_x = sx;
            if (sy < min_y) min_y = sy;
            if (sy > max_y) max_y = sy;
          end
          vx[nverts] = sx;
          vy[nverts] = sy;
          nverts++;
        end
      end
      e.width = cur_w();
      e.height = cur_h();
      if (c == CMD_CLASSIFY) begin
        if (col >= e.width || row >= e.height) begin
          e.status = ST_OFFGRID;
          offgrid_hits++;
        end else begin
          r = longint'(step_size());
          px = min_x - longint'(margin) + longint'(col) * r + (r >>> 1);
          py = min_y - longint'(margin) + longint'(row) * r + (r >>> 1);
          e.hit = crossing_test(px, py);
          e.pixel = e.hit ? PIX_INSIDE : 8'd0;
          e.index = 32'((64'(e.height) - 1 - 64'(row)) * 64'(e.width) + 64'(col));
          if (e.hit) inside_hits++;
        end
      end
      awaited = {awaited, e};
    endfunction

    function void check_word(cell_result_t got);
      cell_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result word with nothing awaited: %p", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.hit !== e.hit) begin
        $display("%0t: inside_res expected %0d got %0d", $time, e.hit, got.hit);
        errors++;
      end
      if (got.pixel !== e.pixel) begin
        $display("%0t: pixel_value expected %0d got %0d", $time, e.pixel, got.pixel);
        errors++;
      end
      if (got.index !== e.index) begin
        $display("%0t: pixel_index expected %0d got %0d", $time, e.index, got.index);
        errors++;
      end
      if (got.width !== e.width) begin
        $display("%0t: grid_width expected %0d got %0d", $time, e.width, got.width);
        errors++;
      end
      if (got.height !== e.height) begin
        $display("%0t: grid_height expected %0d got %0d", $time, e.height, got.height);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PAD_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] cmd;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [15:0] cell_col;
  logic [15:0] cell_row;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic inside_res;
  logic [7:0] pixel_value;
  logic [31:0] pixel_index;
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  mask_scoreboard sb;
  int sender_idle_pct;
  int receiver_stall_pct;
  int words_sent;
  int phase_count;
  longint cycles;

  polygon_mask_rasterizer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .vertex_x(vertex_x), .vertex_y(vertex_y),
    .cell_col(cell_col), .cell_row(cell_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .inside_res(inside_res), .pixel_value(pixel_value),
    .pixel_index(pixel_index), .grid_width(grid_width), .grid_height(grid_height)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, decided once per cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Result words are checked at the rising edge where they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word('{status, inside_res, pixel_value, pixel_index, grid_width, grid_height});
    end
  end

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words awaited", cycles, sb.awaited.size());
      $display("FAIL polygon_mask_rasterizer_unit");
      $finish;
    end
  end

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // Drives one input word starting at a falling edge and returns at the
  // falling edge after it was taken. Valid is only lowered for a real gap,
  // so it never drops and rises within one time step.
  task automatic send_word(logic [1:0] c, logic [39:0] x, logic [39:0] y,
                           logic [15:0] col, logic [15:0] row);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    vertex_x <= x;
    vertex_y <= y;
    cell_col <= col;
    cell_row <= row;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_word(c, x, y, col, row);
    words_sent++;
    @(negedge clk);
  endtask

  // Lets every awaited word come back, then the block settle, and writes
  // one register while the block is idle.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Classifies a cell picked mostly on the grid or one step past its edge.
  task automatic classify_near_grid();
    logic [15:0] col, row;
    if ($urandom_range(15) == 0) begin
      col = rand16();
      row = rand16();
    end else begin
      col = 16'($urandom_range(sb.cur_w(), 0));
      row = 16'($urandom_range(sb.cur_h(), 0));
    end
    send_word(CMD_CLASSIFY, rand40(), rand40(), col, row);
  endtask

  // One polygon: clear, a run of vertices mostly clustered on a random origin,
  // then a batch of cell queries.
  task automatic random_polygon();
    int n;
    longint spread;
    logic [39:0] bx, by, x, y;
    bit wide;
    n = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 3);
    wide = ($urandom_range(9) == 0);
    spread = longint'(sb.step_size()) * $urandom_range(30, 2);
    bx = {{20{1'b0}}, 20'($urandom)} - 40'd524288;
    by = {{20{1'b0}}, 20'($urandom)} - 40'd524288;
    send_word(CMD_CLEAR, rand40(), rand40(), rand16(), rand16());
    for (int k = 0; k < n; k++) begin
      if (wide) begin
        x = rand40();
        y = rand40();
      end else begin
        x = bx + 40'($urandom_range(int'(spread), 0));
        y = by + 40'($urandom_range(int'(spread), 0));
      end
      send_word(CMD_APPEND, x, y, rand16(), rand16());
    end
    repeat ($urandom_range(12, 4)) classify_near_grid();
  endtask

  // Stray words: unused selector, lone appends, clears and classifies.
  task automatic noise_word();
    case ($urandom_range(3))
      0: send_word(CMD_UNUSED, rand40(), rand40(), rand16(), rand16());
      1: send_word(CMD_APPEND, rand40(), rand40(), rand16(), rand16());
      2: send_word(CMD_CLEAR, rand40(), rand40(), rand16(), rand16());
      default: send_word(CMD_CLASSIFY, rand40(), rand40(), rand16(), rand16());
    endcase
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      1: begin sender_idle_pct = 69; receiver_stall_pct = 0; end
      2: begin sender_idle_pct = 0; receiver_stall_pct = 69; end
      default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
    endcase
  endtask

  initial begin
    logic [15:0] res_pick;
    logic [23:0] pad_pick;
    int target;
    sb = new();
    cycles = 0;
    words_sent = 0;
    phase_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_RES;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cmd = CMD_CLEAR;
    vertex_x = '0;
    vertex_y = '0;
    cell_col = '0;
    cell_row = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset cell size and padding.
    send_word(CMD_CLASSIFY, '0, '0, 16'd0, 16'd0);          // empty polygon
    send_word(CMD_UNUSED, rand40(), rand40(), 16'hFFFF, 16'hFFFF);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
    send_word(CMD_APPEND, 40'd0, 40'd0, '0, '0);
    send_word(CMD_APPEND, 40'd2560, 40'd0, '0, '0);
    send_word(CMD_APPEND, 40'd1280, 40'd2560, '0, '0);
    send_word(CMD_CLASSIFY, '0, '0, 16'd0, 16'd0);
    send_word(CMD_CLASSIFY, '0, '0, 16'd105, 16'd105);
    send_word(CMD_CLASSIFY, '0, '0, 16'd110, 16'd101);
    send_word(CMD_CLASSIFY, '0, '0, 16'd219, 16'd0);
    send_word(CMD_CLASSIFY, '0, '0, 16'hFFFF, 16'd3);        // off grid
    send_word(CMD_CLASSIFY, '0, '0, 16'd3, 16'hFFFF);
    send_word(CMD_CLEAR, '0, '0, '0, '0);
    // Coordinate extremes: the grid saturates in both directions.
    send_word(CMD_APPEND, 40'h8000000000, 40'h8000000000, '0, '0);
    send_word(CMD_APPEND, 40'h7FFFFFFFFF, 40'h8000000000, '0, '0);
    send_word(CMD_APPEND, 40'h7FFFFFFFFF, 40'h7FFFFFFFFF, '0, '0);
    send_word(CMD_APPEND, 40'h8000000000, 40'h7FFFFFFFFF, '0, '0);
    send_word(CMD_CLASSIFY, '0, '0, 16'd0, 16'd0);
    send_word(CMD_CLASSIFY, '0, '0, 16'd32767, 16'd32767);
    send_word(CMD_CLASSIFY, '0, '0, 16'hFFFE, 16'hFFFE);
    send_word(CMD_CLASSIFY, '0, '0, 16'hFFFF, 16'd0);

    // Random phases, each with its own cell size, padding and idle mode.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin res_pick = 16'd1; pad_pick = 24'd0; end
        1: begin res_pick = 16'hFFFF; pad_pick = 24'hFFFFFF; end
        2: begin res_pick = 16'd0; pad_pick = 24'($urandom_range(4096)); end
        3: begin res_pick = 16'd256; pad_pick = 24'd0; end
        4: begin res_pick = 16'hFFFF; pad_pick = 24'd0; end
        5: begin res_pick = 16'd1; pad_pick = 24'hFFFFFF; end
        default: begin res_pick = 16'($urandom); pad_pick = 24'($urandom); end
      endcase
      set_reg(REG_RES, {8'd0, res_pick});
      set_reg(REG_PAD, pad_pick);
      set_idle_mode(p % 4);
      phase_count++;
      target = words_sent + 235;
      while (words_sent < target) begin
        if ($urandom_range(24) == 0) noise_word();
        else random_polygon();
      end
    end

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d words over %0d register settings and four idle patterns.",
             words_sent, phase_count + 1);
    $display("Inside cells %0d, table-full appends %0d, off-grid cells %0d, errors %0d.",
             sb.inside_hits, sb.full_hits, sb.offgrid_hits, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS polygon_mask_rasterizer_unit");
    end else begin
      $display("FAIL polygon_mask_rasterizer_unit");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pmr_pkg.sv
sv/pmr_grid_div.sv
sv/polygon_mask_rasterizer_unit.sv
sv/pmr_checker.sv
test/tb.sv
